// File: design/tkf_pkg.sv
`timescale 1ns / 1ps
package tkf_pkg;

  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned TALLY_W   = 16;
  localparam int unsigned CFG_W     = 4;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;
  localparam logic [CFG_W-1:0]   TOP_COUNT_RESET = 4'd3;

  // request handed from the front queue to the engine
  typedef struct packed {
    logic                      start_new;
    logic signed [VALUE_W-1:0] value;
  } tkf_item_t;

endpackage

// File: design/tkf_front.sv
`timescale 1ns / 1ps
module tkf_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_start_new,
  input  logic signed [tkf_pkg::VALUE_W-1:0] in_sample_value,
  output logic                              item_valid,
  output tkf_pkg::tkf_item_t                item,
  input  logic                              item_pop
);

  tkf_pkg::tkf_item_t q_mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall   = (cnt_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (cnt_r != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = q_mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r].start_new <= in_start_new;
      q_mem_r[wr_ptr_r].value     <= in_sample_value;
    end
  end

endmodule

// File: design/tkf_engine.sv
`timescale 1ns / 1ps
module tkf_engine #(
  parameter int TABLE_DEPTH = 64,
  parameter int K_MAX       = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [tkf_pkg::CFG_W-1:0]          top_count,
  input  logic                               item_valid,
  input  tkf_pkg::tkf_item_t                 item,
  output logic                               item_pop,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tkf_pkg::VALUE_W-1:0] out_ranked_value,
  output logic [tkf_pkg::TALLY_W-1:0]        out_ranked_count,
  output logic                               out_table_full_drop,
  output logic                               out_last_of_run
);

  localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW  = $clog2(TABLE_DEPTH + 1);
  localparam int KW  = $clog2(K_MAX + 1);
  localparam int LW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int KCW = (KW > tkf_pkg::CFG_W) ? KW : tkf_pkg::CFG_W;
  localparam int CW  = (UW > KW) ? UW : KW;
  localparam int VW  = tkf_pkg::VALUE_W;
  localparam int TW  = tkf_pkg::TALLY_W;

  typedef enum logic [2:0] {S_IDLE, S_SRCH, S_UPD, S_RANK, S_EMIT} state_t;

  state_t                state_r, state_nxt;
  logic signed [VW-1:0]  val_r, val_nxt;
  logic [UW-1:0]         used_r, used_nxt;
  logic [UW-1:0]         scan_r, scan_nxt;
  logic                  rvld_r, rvld_nxt;
  logic [AW-1:0]         ridx_r, ridx_nxt;
  logic                  hit_r, hit_nxt;
  logic [AW-1:0]         hit_idx_r, hit_idx_nxt;
  logic [TW-1:0]         hit_tally_r, hit_tally_nxt;
  logic                  drop_r, drop_nxt;
  logic [KW-1:0]         lst_cnt_r, lst_cnt_nxt;
  logic signed [VW-1:0]  lst_key_r [K_MAX];
  logic signed [VW-1:0]  lst_key_nxt [K_MAX];
  logic [TW-1:0]         lst_tally_r [K_MAX];
  logic [TW-1:0]         lst_tally_nxt [K_MAX];
  logic [KW-1:0]         emit_r, emit_nxt;
  logic [KW-1:0]         n_r, n_nxt;
  logic                  ov_r, ov_nxt;
  logic signed [VW-1:0]  ovalue_r, ovalue_nxt;
  logic [TW-1:0]         ocount_r, ocount_nxt;
  logic                  odrop_r, odrop_nxt;
  logic                  olast_r, olast_nxt;

  logic signed [VW-1:0]  key_mem [TABLE_DEPTH];
  logic [TW-1:0]         tally_mem [TABLE_DEPTH];
  logic signed [VW-1:0]  key_q;
  logic [TW-1:0]         tally_q;
  logic                  mem_re, mem_we;
  logic [AW-1:0]         mem_waddr;
  logic signed [VW-1:0]  mem_wkey;
  logic [TW-1:0]         mem_wtally;

  logic [K_MAX-1:0]      ranks_ahead;
  logic [KCW-1:0]        k_wide;
  logic [KW-1:0]         k_eff;
  logic                  scan_done;
  logic                  out_free;

  assign mem_re    = (state_r == S_SRCH || state_r == S_RANK) && (scan_r < used_r);
  assign scan_done = !rvld_r && (scan_r == used_r);
  assign out_free  = !ov_r || !out_stall;
  assign item_pop  = (state_r == S_IDLE) && item_valid;

  // zero acts as one, anything above the list depth is clamped
  always_comb begin
    k_wide = KCW'(top_count);
    if (k_wide == '0) begin
      k_eff = KW'(1);
    end else if (k_wide > KCW'(K_MAX)) begin
      k_eff = KW'(K_MAX);
    end else begin
      k_eff = KW'(k_wide);
    end
  end

  // sorted insert of the returning entry into the running top list
  always_comb begin
    for (int j = 0; j < K_MAX; j++) begin
      ranks_ahead[j] = (KW'(j) >= lst_cnt_r) || (tally_q > lst_tally_r[j]) ||
                       ((tally_q == lst_tally_r[j]) && (key_q < lst_key_r[j]));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    used_nxt      = used_r;
    scan_nxt      = scan_r;
    rvld_nxt      = mem_re;
    ridx_nxt      = scan_r[AW-1:0];
    hit_nxt       = hit_r;
    hit_idx_nxt   = hit_idx_r;
    hit_tally_nxt = hit_tally_r;
    drop_nxt      = drop_r;
    lst_cnt_nxt   = lst_cnt_r;
    lst_key_nxt   = lst_key_r;
    lst_tally_nxt = lst_tally_r;
    emit_nxt      = emit_r;
    n_nxt         = n_r;
    ov_nxt        = ov_r && out_stall;
    ovalue_nxt    = ovalue_r;
    ocount_nxt    = ocount_r;
    odrop_nxt     = odrop_r;
    olast_nxt     = olast_r;
    mem_we        = 1'b0;
    mem_waddr     = hit_idx_r;
    mem_wkey      = val_r;
    mem_wtally    = (hit_tally_r == tkf_pkg::TALLY_MAX) ? hit_tally_r : hit_tally_r + TW'(1);
    if (mem_re) begin
      scan_nxt = scan_r + UW'(1);
    end

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          val_nxt   = item.value;
          scan_nxt  = '0;
          hit_nxt   = 1'b0;
          if (item.start_new) begin
            used_nxt = '0;
          end
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (rvld_r && key_q == val_r) begin
          hit_nxt       = 1'b1;
          hit_idx_nxt   = ridx_r;
          hit_tally_nxt = tally_q;
          state_nxt     = S_UPD;
        end else if (scan_done) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        drop_nxt = 1'b0;
        if (hit_r) begin
          mem_we = 1'b1;
        end else if (used_r < UW'(TABLE_DEPTH)) begin
          mem_we     = 1'b1;
          mem_waddr  = used_r[AW-1:0];
          mem_wtally = TW'(1);
          used_nxt   = used_r + UW'(1);
        end else begin
          drop_nxt = 1'b1;
        end
        scan_nxt    = '0;
        lst_cnt_nxt = '0;
        state_nxt   = S_RANK;
      end
      S_RANK: begin
        if (rvld_r) begin
          for (int j = 0; j < K_MAX; j++) begin
            if (ranks_ahead[j]) begin
              if (j == 0) begin
                lst_key_nxt[j]   = key_q;
                lst_tally_nxt[j] = tally_q;
              end else if (!ranks_ahead[(j > 0) ? j - 1 : 0]) begin
                lst_key_nxt[j]   = key_q;
                lst_tally_nxt[j] = tally_q;
              end else begin
                lst_key_nxt[j]   = lst_key_r[(j > 0) ? j - 1 : 0];
                lst_tally_nxt[j] = lst_tally_r[(j > 0) ? j - 1 : 0];
              end
            end
          end
          if (lst_cnt_r != KW'(K_MAX)) begin
            lst_cnt_nxt = lst_cnt_r + KW'(1);
          end
        end else if (scan_done) begin
          n_nxt     = (CW'(used_r) < CW'(k_eff)) ? KW'(used_r) : k_eff;
          emit_nxt  = '0;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          ov_nxt     = 1'b1;
          ovalue_nxt = lst_key_r[emit_r[LW-1:0]];
          ocount_nxt = lst_tally_r[emit_r[LW-1:0]];
          odrop_nxt  = drop_r;
          olast_nxt  = (emit_r == n_r - KW'(1));
          emit_nxt   = emit_r + KW'(1);
          if (emit_r == n_r - KW'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      rvld_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      rvld_r  <= rvld_nxt;
      ov_r    <= ov_nxt;
    end
    val_r       <= val_nxt;
    scan_r      <= scan_nxt;
    ridx_r      <= ridx_nxt;
    hit_r       <= hit_nxt;
    hit_idx_r   <= hit_idx_nxt;
    hit_tally_r <= hit_tally_nxt;
    drop_r      <= drop_nxt;
    lst_cnt_r   <= lst_cnt_nxt;
    lst_key_r   <= lst_key_nxt;
    lst_tally_r <= lst_tally_nxt;
    emit_r      <= emit_nxt;
    n_r         <= n_nxt;
    ovalue_r    <= ovalue_nxt;
    ocount_r    <= ocount_nxt;
    odrop_r     <= odrop_nxt;
    olast_r     <= olast_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[mem_waddr]   <= mem_wkey;
      tally_mem[mem_waddr] <= mem_wtally;
    end
    if (mem_re) begin
      key_q   <= key_mem[scan_r[AW-1:0]];
      tally_q <= tally_mem[scan_r[AW-1:0]];
    end
  end

  assign out_valid           = ov_r;
  assign out_ranked_value    = ovalue_r;
  assign out_ranked_count    = ocount_r;
  assign out_table_full_drop = odrop_r;
  assign out_last_of_run     = olast_r;

endmodule

// File: design/stream_top_k_frequent.sv
`timescale 1ns / 1ps
// Counts signed 32-bit samples in a table of up to TABLE_DEPTH distinct values and, after
// each sample, emits at most top_count (clamped to 1..K_MAX) most frequent entries, highest
// count first and smaller value first on ties; the last result of each sample is flagged.
// A two-entry input queue lets samples arrive while the engine works. For each sample,
// the single read port of the table memory is swept once to find the value and once to
// rank the entries.
module stream_top_k_frequent #(
  parameter int TABLE_DEPTH = 64,
  parameter int K_MAX       = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [tkf_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_start_new,
  input  logic signed [tkf_pkg::VALUE_W-1:0] in_sample_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [tkf_pkg::VALUE_W-1:0] out_ranked_value,
  output logic [tkf_pkg::TALLY_W-1:0]        out_ranked_count,
  output logic                               out_table_full_drop,
  output logic                               out_last_of_run
);

  logic [tkf_pkg::CFG_W-1:0] top_count_r;
  logic                      item_valid;
  logic                      item_pop;
  tkf_pkg::tkf_item_t        item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_count_r <= tkf_pkg::TOP_COUNT_RESET;
    end else if (cfg_wr_en) begin
      top_count_r <= cfg_wr_data;
    end
  end

  tkf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_start_new    (in_start_new),
    .in_sample_value (in_sample_value),
    .item_valid      (item_valid),
    .item            (item),
    .item_pop        (item_pop)
  );

  tkf_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .K_MAX       (K_MAX)
  ) u_engine (
    .clk                 (clk),
    .rst_n               (rst_n),
    .top_count           (top_count_r),
    .item_valid          (item_valid),
    .item                (item),
    .item_pop            (item_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_ranked_value    (out_ranked_value),
    .out_ranked_count    (out_ranked_count),
    .out_table_full_drop (out_table_full_drop),
    .out_last_of_run     (out_last_of_run)
  );

endmodule

// File: design/tkf_checker.sv
`timescale 1ns / 1ps
module tkf_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [tkf_pkg::VALUE_W-1:0] out_ranked_value,
  input logic [tkf_pkg::TALLY_W-1:0]        out_ranked_count,
  input logic                               out_table_full_drop,
  input logic                               out_last_of_run
);

  a_no_out_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ranked_value) &&
      $stable(out_ranked_count) && $stable(out_last_of_run))
    else $error("stalled result changed");

  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid &&
      (out_table_full_drop == $past(out_table_full_drop)))
    else $error("run broken before its last result");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ranked_count != '0)
    else $error("ranked count of zero");

endmodule

bind stream_top_k_frequent tkf_checker u_tkf_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_ranked_value    (out_ranked_value),
  .out_ranked_count    (out_ranked_count),
  .out_table_full_drop (out_table_full_drop),
  .out_last_of_run     (out_last_of_run)
);
